/* rtl/core/assert_macros.svh */
// assertion macros used by the checker eobm_checker
// needs aclk and aresetn in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define EOBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define EOBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/eobm_pkg.sv */
// types and constants of the edge orientation background model
// no dependencies
package eobm_pkg;

    localparam int W_W        = 16;
    localparam int ALPHA_W    = 22;
    localparam int THR_W      = 16;
    localparam int CNT_W      = 8;
    localparam int V_W        = 23;
    localparam int D_W        = 23;
    localparam int N_W        = 41;
    localparam int Q_W        = 16;
    localparam int RC_W       = 9;
    localparam int SUM_W      = 20;
    localparam int PIX_W      = 19;
    localparam int PIXMAX_W   = 22;
    localparam int CODE_W     = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam int             WEIGHT_ONE = 64000;
    localparam logic [16:0]    SCALE2     = 17'd128000;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PER_NE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PER_E   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_CLASSIFY = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_INIT     = 2'd2
    } op_t;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [CODE_W-1:0]   code;
        logic [PIXMAX_W-1:0] pix;
    } req_t;

    typedef struct packed {
        logic                valid;
        logic [PIXMAX_W-1:0] pix;
        logic                fg;
        logic                bad;
        logic                init;
        logic                wr_w;
        logic                wr_ne;
        logic                wr_e;
        logic                dz;
        logic [RC_W-1:0]     rc;
        logic [CNT_W-1:0]    period;
    } ctl_t;

endpackage

/* rtl/core/eobm_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage for every weight lane
// also reduces the skip counter modulo its period; uses eobm_pkg
module eobm_div_pipe #(
    parameter int NUM_CODES = 5
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  eobm_pkg::ctl_t                            ctl_in,
    input  logic [NUM_CODES-1:0][eobm_pkg::N_W-1:0]   num_in,
    input  logic [eobm_pkg::D_W:0]                    den_in,
    input  logic [eobm_pkg::PIXMAX_W-1:0]             chk_pix,
    output logic                                      hit,
    output eobm_pkg::ctl_t                            ctl_out,
    output logic [NUM_CODES-1:0][eobm_pkg::Q_W-1:0]   quo_out
);
    import eobm_pkg::*;

    ctl_t                           ctl_reg [Q_W];
    logic [NUM_CODES-1:0][N_W-1:0]  rem_reg [Q_W];
    logic [NUM_CODES-1:0][Q_W-1:0]  quo_reg [Q_W];
    logic [D_W:0]                   den_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B  = Q_W - 1 - j;
        localparam int CB = (j < RC_W) ? (RC_W - 1 - j) : 0;

        ctl_t                           ctl_prev;
        ctl_t                           ctl_next;
        logic [NUM_CODES-1:0][N_W-1:0]  rem_prev;
        logic [NUM_CODES-1:0][N_W-1:0]  rem_next;
        logic [NUM_CODES-1:0][Q_W-1:0]  quo_prev;
        logic [NUM_CODES-1:0][Q_W-1:0]  quo_next;
        logic [D_W:0]                   den_prev;

        if (j == 0) begin : g_first
            assign ctl_prev = ctl_in;
            assign rem_prev = num_in;
            assign quo_prev = '0;
            assign den_prev = den_in;
        end else begin : g_rest
            assign ctl_prev = ctl_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign den_prev = den_reg[j-1];
        end

        always_comb begin
            logic [N_W-1:0]        trial;
            logic [RC_W+CNT_W-1:0] ctrial;
            trial    = N_W'(den_prev) << B;
            ctrial   = (RC_W+CNT_W)'(ctl_prev.period) << CB;
            rem_next = rem_prev;
            quo_next = quo_prev;
            ctl_next = ctl_prev;
            for (int i = 0; i < NUM_CODES; i++) begin
                if (rem_prev[i] >= trial) begin
                    rem_next[i]    = rem_prev[i] - trial;
                    quo_next[i][B] = 1'b1;
                end
            end
            if (j < RC_W) begin
                if ((RC_W+CNT_W)'(ctl_prev.rc) >= ctrial) begin
                    ctl_next.rc = ctl_prev.rc - RC_W'(ctrial);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j] <= '0;
            end else if (en) begin
                ctl_reg[j] <= ctl_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                den_reg[j] <= den_prev;
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int j = 0; j < Q_W; j++) begin
            if (ctl_reg[j].valid && ctl_reg[j].pix == chk_pix) begin
                hit = 1'b1;
            end
        end
    end

    assign ctl_out = ctl_reg[Q_W-1];
    assign quo_out = quo_reg[Q_W-1];

endmodule

/* rtl/core/edge_orientation_background_model.sv */
// top level of the edge orientation background model
// uses eobm_pkg and eobm_div_pipe
//
// input channel s_*: one transaction per pixel, operation classify, update or
// initialise, pixel index and orientation code. result channel m_*: exactly one
// transaction per input, in order, with foreground and bad_code.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 alpha_step, 1 fg_threshold, 2 period_no_edge, 3 period_edge).
// path from input transaction to result valid: memory read, decode, scaling
// multiply, 16 divider stages, output register.
// throughput: one transaction per cycle while no stall or pixel wait holds; the
// divider stages set the latency. an input whose pixel is still in flight waits
// until that pixel's write-back.
// reset: control state and configuration registers return to defaults; the
// model memories are not cleared, a pixel must be initialised before use.
// stall: while m_valid is high and m_ready low the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
module edge_orientation_background_model #(
    parameter int NUM_CODES  = 5,
    parameter int NUM_PIXELS = 524288
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [eobm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [eobm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [eobm_pkg::OP_W-1:0]         s_operation,
    input  logic [eobm_pkg::PIX_W-1:0]        s_pixel_index,
    input  logic [eobm_pkg::CODE_W-1:0]       s_orientation,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_foreground,
    output logic                              m_bad_code
);
    import eobm_pkg::*;

    localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int RW = NUM_CODES * W_W;
    localparam logic [W_W-1:0] INIT_W = W_W'((2 * WEIGHT_ONE + NUM_CODES) / (2 * NUM_CODES));

    // configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   per_ne_reg;
    logic [CNT_W-1:0]   per_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_W'(3368);
            thr_reg    <= THR_W'(44800);
            per_ne_reg <= CNT_W'(1);
            per_e_reg  <= CNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ALPHA:  alpha_reg  <= cfg_data;
                REG_THRESH: thr_reg    <= cfg_data[THR_W-1:0];
                REG_PER_NE: per_ne_reg <= cfg_data[CNT_W-1:0];
                REG_PER_E:  per_e_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                en;
    logic                hazard;
    logic                div_hit;
    logic [PIXMAX_W-1:0] s_pix_x;
    req_t                req_a_reg;
    req_t                req_a_next;
    ctl_t                ctl_b_reg;
    ctl_t                ctl_b_next;
    ctl_t                ctl_c_reg;
    ctl_t                div_ctl;
    logic                m_valid_reg;
    logic                m_fg_reg;
    logic                m_bad_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_pix_x = PIXMAX_W'(s_pixel_index);
    assign hazard  = (req_a_reg.valid && req_a_reg.pix == s_pix_x)
                  || (ctl_b_reg.valid && ctl_b_reg.pix == s_pix_x)
                  || (ctl_c_reg.valid && ctl_c_reg.pix == s_pix_x)
                  || div_hit;
    assign s_ready = en && !hazard;

    always_comb begin
        req_a_next.valid = s_valid && s_ready;
        req_a_next.op    = op_t'(s_operation);
        req_a_next.code  = s_orientation;
        req_a_next.pix   = s_pix_x;
    end

    // model memories
    logic [RW-1:0]    wmem   [NUM_PIXELS];
    logic [CNT_W-1:0] cnemem [NUM_PIXELS];
    logic [CNT_W-1:0] cemem  [NUM_PIXELS];
    logic [RW-1:0]    rd_w_reg;
    logic [CNT_W-1:0] rd_ne_reg;
    logic [CNT_W-1:0] rd_e_reg;
    logic [AW-1:0]    wr_addr;
    logic [RW-1:0]    wr_row;
    logic [CNT_W-1:0] wr_cnt;
    logic             wr_go;
    logic [NUM_CODES-1:0][Q_W-1:0] div_quo;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_w_reg  <= wmem[s_pix_x[AW-1:0]];
            rd_ne_reg <= cnemem[s_pix_x[AW-1:0]];
            rd_e_reg  <= cemem[s_pix_x[AW-1:0]];
        end
    end

    assign wr_go   = en && div_ctl.valid;
    assign wr_addr = div_ctl.pix[AW-1:0];
    assign wr_cnt  = div_ctl.init ? '0 : div_ctl.rc[CNT_W-1:0];

    always_comb begin
        for (int i = 0; i < NUM_CODES; i++) begin
            if (div_ctl.init) begin
                wr_row[i*W_W +: W_W] = INIT_W;
            end else if (div_ctl.dz) begin
                wr_row[i*W_W +: W_W] = '0;
            end else begin
                wr_row[i*W_W +: W_W] = div_quo[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_go && div_ctl.wr_w) begin
            wmem[wr_addr] <= wr_row;
        end
        if (wr_go && div_ctl.wr_ne) begin
            cnemem[wr_addr] <= wr_cnt;
        end
        if (wr_go && div_ctl.wr_e) begin
            cemem[wr_addr] <= wr_cnt;
        end
    end

    // decode stage
    logic [W_W-1:0]   w_a [NUM_CODES];
    logic [V_W-1:0]   v_b_next [NUM_CODES];
    logic [V_W-1:0]   v_b_reg  [NUM_CODES];
    logic [D_W-1:0]   d_b_next;
    logic [D_W-1:0]   d_b_reg;

    always_comb begin
        logic [W_W-1:0]   own;
        logic [SUM_W-1:0] hsum;
        logic             heavier;
        logic             in_rng;
        logic             vp;
        logic             cls;
        logic             upd_op;
        logic             init_op;
        logic             bad;
        logic             upd;
        logic             is_edge;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] per;
        own      = '0;
        hsum     = '0;
        heavier  = 1'b0;
        cls      = 1'b0;
        upd_op   = 1'b0;
        init_op  = 1'b0;
        d_b_next = D_W'(alpha_reg);
        in_rng   = int'(req_a_reg.code) < NUM_CODES;
        vp       = int'(req_a_reg.pix) < NUM_PIXELS;
        is_edge  = req_a_reg.code != '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            w_a[i] = rd_w_reg[i*W_W +: W_W];
            if (i == int'(req_a_reg.code)) begin
                own = w_a[i];
            end
        end
        for (int i = 0; i < NUM_CODES; i++) begin
            if (i != int'(req_a_reg.code) && w_a[i] > own) begin
                hsum    = hsum + SUM_W'(w_a[i]);
                heavier = 1'b1;
            end
            d_b_next    = d_b_next + D_W'(w_a[i]);
            v_b_next[i] = V_W'(w_a[i])
                        + ((i == int'(req_a_reg.code)) ? V_W'(alpha_reg) : '0);
        end
        case (req_a_reg.op)
            OP_CLASSIFY: cls     = 1'b1;
            OP_UPDATE:   upd_op  = 1'b1;
            OP_INIT:     init_op = 1'b1;
            default: ;
        endcase
        bad = (cls || upd_op) && !in_rng;
        upd = upd_op && !bad && vp;
        cnt = is_edge ? rd_e_reg : rd_ne_reg;
        per = is_edge ? per_e_reg : per_ne_reg;
        if (per == '0) begin
            per = CNT_W'(1);
        end
        ctl_b_next.valid  = req_a_reg.valid;
        ctl_b_next.pix    = req_a_reg.pix;
        ctl_b_next.fg     = cls && !bad && vp && is_edge && heavier
                         && (hsum >= SUM_W'(thr_reg));
        ctl_b_next.bad    = bad;
        ctl_b_next.init   = init_op && vp;
        ctl_b_next.wr_w   = (init_op && vp) || (upd && cnt == '0);
        ctl_b_next.wr_ne  = (init_op && vp) || (upd && !is_edge);
        ctl_b_next.wr_e   = (init_op && vp) || (upd && is_edge);
        ctl_b_next.dz     = d_b_next == '0;
        ctl_b_next.rc     = RC_W'(cnt) + RC_W'(1);
        ctl_b_next.period = per;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else if (en) begin
            req_a_reg <= req_a_next;
            ctl_b_reg <= ctl_b_next;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    // scaling stage
    logic [NUM_CODES-1:0][N_W-1:0] n_c_reg;
    logic [D_W:0]                  den_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            v_b_reg <= v_b_next;
            d_b_reg <= d_b_next;
            for (int i = 0; i < NUM_CODES; i++) begin
                n_c_reg[i] <= N_W'(v_b_reg[i]) * N_W'(SCALE2) + N_W'(d_b_reg);
            end
            den_c_reg <= {d_b_reg, 1'b0};
        end
    end

    eobm_div_pipe #(
        .NUM_CODES(NUM_CODES)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (ctl_c_reg),
        .num_in  (n_c_reg),
        .den_in  (den_c_reg),
        .chk_pix (s_pix_x),
        .hit     (div_hit),
        .ctl_out (div_ctl),
        .quo_out (div_quo)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_fg_reg  <= div_ctl.fg;
            m_bad_reg <= div_ctl.bad;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_foreground = m_fg_reg;
    assign m_bad_code   = m_bad_reg;

endmodule

/* rtl/core/eobm_checker.sv */
// port-level checks for the edge orientation background model
// uses assert_macros.svh, bound to the top level below
`include "assert_macros.svh"

module eobm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_foreground,
    input logic       m_bad_code
);

    `EOBM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `EOBM_ASSERT(a_fg_not_bad, m_valid |-> !(m_foreground && m_bad_code), "foreground with bad code")
    `EOBM_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_foreground) && $stable(m_bad_code), "result changed under stall")
    `EOBM_ASSERT(a_stall_blocks_input, m_valid && !m_ready |-> !s_ready, "input taken while result stalled")

endmodule

bind edge_orientation_background_model eobm_checker u_eobm_checker (.*);
